FILE: rtl/aminv_pkg.sv
package aminv_pkg;

    localparam int THR_W = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd1;
    localparam logic REG_DET_THRESHOLD = 1'b0;
    localparam int ROWS = 3;
    localparam logic [1:0] LAST_ROW_IDX = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: rtl/aminv_div.sv
module aminv_div #(
    parameter int E  = 32,
    parameter int NW = 131,
    parameter int DW = 99
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic [DW-1:0]        i_den,
    input  logic                 i_den_neg,
    output logic                 o_busy,
    output logic [E-1:0]         o_quo
);
    localparam int RW = (NW - E > DW) ? NW - E + 1 : DW + 1;
    localparam int CW = $clog2(E + 1);

    logic          r_busy, r_chk, r_neg, r_sat;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] r_rem;
    logic [E-1:0]  r_low;
    logic [DW-1:0] r_den;
    logic [NW-1:0] w_mag;
    logic [RW-1:0] w_sh;
    logic          w_ge;
    logic [E-1:0]  w_max, w_min;

    assign w_mag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    assign w_sh  = {r_rem[RW-2:0], r_low[E-1]};
    assign w_ge  = w_sh >= RW'(r_den);
    assign w_max = {1'b0, {(E-1){1'b1}}};
    assign w_min = {1'b1, {(E-1){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_chk  <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_chk  <= 1'b1;
        end else if (r_chk) begin
            r_chk <= 1'b0;
        end else if (r_busy && r_cnt == CW'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= RW'(w_mag >> E);
            r_low <= w_mag[E-1:0];
            r_den <= i_den;
            r_neg <= i_num[NW-1] ^ i_den_neg;
            r_cnt <= CW'(E);
        end else if (r_chk) begin
            r_sat <= r_rem >= RW'(r_den);
        end else if (r_busy) begin
            r_rem <= w_ge ? RW'(w_sh - RW'(r_den)) : w_sh;
            r_low <= {r_low[E-2:0], w_ge};
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_comb begin
        if (r_sat) begin
            o_quo = r_neg ? w_min : w_max;
        end else if (!r_neg) begin
            o_quo = r_low[E-1] ? w_max : r_low;
        end else if (r_low[E-1] && |r_low[E-2:0]) begin
            o_quo = w_min;
        end else begin
            o_quo = E'(-r_low);
        end
    end

    assign o_busy = r_busy;

endmodule

FILE: rtl/aminv_fifo.sv
module aminv_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [W-1:0]          i_data,
    input  logic                  i_pop,
    output logic [W-1:0]          o_data,
    output aminv_pkg::t_q_status  o_status
);
    import aminv_pkg::*;

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [PTRW-1:0] r_wr, r_rd;
    logic [CNTW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTRW'(DEPTH - 1)) ? '0 : r_wr + PTRW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTRW'(DEPTH - 1)) ? '0 : r_rd + PTRW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = r_cnt == CNTW'(DEPTH);
    assign o_status.empty = r_cnt == '0;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty) else $error("queue read while empty");
`endif

endmodule

FILE: rtl/aminv_front.sv
module aminv_front #(
    parameter int E = 32,
    parameter int F = 16,
    localparam int A  = 2 * E + 1,
    localparam int SW = 3 * E + 3,
    localparam int PW = 9 * A + 4 * SW + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [11:0][E-1:0]           i_m,
    input  logic [aminv_pkg::THR_W-1:0]  i_thr,
    output logic                         o_q_valid,
    input  logic                         i_q_full,
    output logic [PW-1:0]                o_q_data
);
    import aminv_pkg::*;

    localparam int CW = (SW > THR_W + 2 * F) ? SW : THR_W + 2 * F;

    logic signed [E-1:0]   w_m [3][4];
    logic [4:1]            r_v;
    logic                  w_en;
    logic signed [2*E-1:0] r_pa [3][3];
    logic signed [2*E-1:0] r_pb [3][3];
    logic signed [E-1:0]   r_m1 [3];
    logic signed [E-1:0]   r_t1 [3];
    logic signed [A-1:0]   r_adj2 [3][3];
    logic signed [E-1:0]   r_m2 [3];
    logic signed [E-1:0]   r_t2 [3];
    logic signed [A-1:0]   r_adj3 [3][3];
    logic signed [2*E:0]   r_phd [3];
    logic signed [2*E:0]   r_pld [3];
    logic signed [2*E:0]   r_pht [3][3];
    logic signed [2*E:0]   r_plt [3][3];
    logic signed [A-1:0]   r_adj4 [3][3];
    logic signed [SW-1:0]  r_det;
    logic signed [SW-1:0]  r_tt [3];
    logic [SW-1:0]         w_abs;
    logic                  w_sing;

    function automatic logic signed [SW-1:0] f_join(input logic signed [2*E:0] ph,
                                                    input logic signed [2*E:0] pl);
        return (SW'(ph) <<< E) + SW'(pl);
    endfunction

    always_comb begin
        for (int k = 0; k < 12; k++) begin
            w_m[k/4][k%4] = $signed(i_m[k]);
        end
    end

    assign w_en      = !r_v[4] || !i_q_full;
    assign o_ready   = w_en;
    assign o_q_valid = r_v[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[3:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pa[r][c] <= w_m[(c+1)%3][(r+1)%3] * w_m[(c+2)%3][(r+2)%3];
                    r_pb[r][c] <= w_m[(c+1)%3][(r+2)%3] * w_m[(c+2)%3][(r+1)%3];
                    r_adj2[r][c] <= A'(r_pa[r][c]) - A'(r_pb[r][c]);
                    r_adj3[r][c] <= r_adj2[r][c];
                    r_adj4[r][c] <= r_adj3[r][c];
                    r_pht[r][c] <= r_t2[c] * $signed(r_adj2[r][c][2*E:E]);
                    r_plt[r][c] <= r_t2[c] * $signed({1'b0, r_adj2[r][c][E-1:0]});
                end
                r_m1[r]  <= w_m[0][r];
                r_t1[r]  <= w_m[r][3];
                r_m2[r]  <= r_m1[r];
                r_t2[r]  <= r_t1[r];
                r_phd[r] <= r_m2[r] * $signed(r_adj2[r][0][2*E:E]);
                r_pld[r] <= r_m2[r] * $signed({1'b0, r_adj2[r][0][E-1:0]});
                r_tt[r]  <= -(f_join(r_pht[r][0], r_plt[r][0])
                            + f_join(r_pht[r][1], r_plt[r][1])
                            + f_join(r_pht[r][2], r_plt[r][2]));
            end
            r_det <= f_join(r_phd[0], r_pld[0]) + f_join(r_phd[1], r_pld[1])
                   + f_join(r_phd[2], r_pld[2]);
        end
    end

    assign w_abs  = r_det[SW-1] ? SW'(-r_det) : SW'(r_det);
    assign w_sing = CW'(w_abs) <= (CW'(i_thr) << (2 * F));

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            o_q_data[k*A +: A] = r_adj4[k/3][k%3];
        end
        for (int r = 0; r < 3; r++) begin
            o_q_data[9*A + r*SW +: SW] = r_tt[r];
        end
        o_q_data[9*A + 3*SW +: SW] = w_abs;
        o_q_data[PW-2] = r_det[SW-1];
        o_q_data[PW-1] = w_sing;
    end

endmodule

FILE: rtl/aminv_back.sv
module aminv_back #(
    parameter int E = 32,
    parameter int F = 16,
    localparam int A  = 2 * E + 1,
    localparam int SW = 3 * E + 3,
    localparam int PW = 9 * A + 4 * SW + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  logic [PW-1:0]        i_q_data,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_row_index,
    output logic [E-1:0]         o_c0,
    output logic [E-1:0]         o_c1,
    output logic [E-1:0]         o_c2,
    output logic [E-1:0]         o_t,
    output logic                 o_singular,
    output logic                 o_last_row
);
    import aminv_pkg::*;

    localparam int NW = SW + 2 * F;

    t_back_state          r_state;
    logic [1:0]           r_row;
    logic                 r_sing;
    logic                 r_o_valid;
    logic [1:0]           r_o_row;
    logic [E-1:0]         r_o_c0, r_o_c1, r_o_c2, r_o_t;
    logic                 r_o_sing, r_o_last;
    logic signed [NW-1:0] w_num [12];
    logic [11:0]          w_busy;
    logic [E-1:0]         w_quo [12];
    logic                 w_start, w_load;
    logic [3:0]           w_base;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_num[k] = NW'($signed(i_q_data[k*A +: A])) <<< (2 * F);
        end
        for (int r = 0; r < 3; r++) begin
            w_num[9+r] = NW'($signed(i_q_data[9*A + r*SW +: SW])) <<< F;
        end
    end

    assign w_start = (r_state == ST_IDLE) && i_q_valid;
    assign o_q_pop = w_start;
    assign w_load  = (r_state == ST_EMIT) && (!r_o_valid || i_ready);
    assign w_base  = {r_row, 1'b0} + {2'b00, r_row};

    for (genvar k = 0; k < 12; k++) begin : g_div
        aminv_div #(.E(E), .NW(NW), .DW(SW)) u_div (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_start   (w_start),
            .i_num     (w_num[k]),
            .i_den     (i_q_data[9*A + 3*SW +: SW]),
            .i_den_neg (i_q_data[PW-2]),
            .o_busy    (w_busy[k]),
            .o_quo     (w_quo[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_start) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (!(|w_busy)) begin
                        r_state <= ST_EMIT;
                        r_row   <= '0;
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        if (r_row == LAST_ROW_IDX) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_row <= r_row + 2'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_sing <= i_q_data[PW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_row  <= r_row;
            r_o_c0   <= r_sing ? '0 : w_quo[w_base];
            r_o_c1   <= r_sing ? '0 : w_quo[w_base + 4'd1];
            r_o_c2   <= r_sing ? '0 : w_quo[w_base + 4'd2];
            r_o_t    <= r_sing ? '0 : w_quo[4'd9 + {2'b00, r_row}];
            r_o_sing <= r_sing;
            r_o_last <= r_row == LAST_ROW_IDX;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_row_index = r_o_row;
    assign o_c0        = r_o_c0;
    assign o_c1        = r_o_c1;
    assign o_c2        = r_o_c2;
    assign o_t         = r_o_t;
    assign o_singular  = r_o_sing;
    assign o_last_row  = r_o_last;

endmodule

FILE: rtl/affine_matrix_inverse_core.sv
// From input accept to the first row, a matrix passes four front stages, the queue write
// and bit-serial division in the back. The twelve dividers produce one quotient bit per
// cycle each; the back takes the next matrix from the queue only after the last row of
// the previous one is loaded, while the front keeps accepting until the queue is full.
// The three rows of a matrix leave on consecutive cycles when the sink is ready.
// Reset is synchronous and active low; it empties the pipeline and queue and sets
// det_threshold to 1.
module affine_matrix_inverse_core #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ELEM_WIDTH-1:0] i_r0c0,
    input  logic [ELEM_WIDTH-1:0] i_r0c1,
    input  logic [ELEM_WIDTH-1:0] i_r0c2,
    input  logic [ELEM_WIDTH-1:0] i_r0t,
    input  logic [ELEM_WIDTH-1:0] i_r1c0,
    input  logic [ELEM_WIDTH-1:0] i_r1c1,
    input  logic [ELEM_WIDTH-1:0] i_r1c2,
    input  logic [ELEM_WIDTH-1:0] i_r1t,
    input  logic [ELEM_WIDTH-1:0] i_r2c0,
    input  logic [ELEM_WIDTH-1:0] i_r2c1,
    input  logic [ELEM_WIDTH-1:0] i_r2c2,
    input  logic [ELEM_WIDTH-1:0] i_r2t,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_row_index,
    output logic [ELEM_WIDTH-1:0] o_out_c0,
    output logic [ELEM_WIDTH-1:0] o_out_c1,
    output logic [ELEM_WIDTH-1:0] o_out_c2,
    output logic [ELEM_WIDTH-1:0] o_out_t,
    output logic                  o_singular,
    output logic                  o_last_row
);
    import aminv_pkg::*;

    localparam int A  = 2 * ELEM_WIDTH + 1;
    localparam int SW = 3 * ELEM_WIDTH + 3;
    localparam int PW = 9 * A + 4 * SW + 2;

    logic [THR_W-1:0]               r_thr;
    logic [11:0][ELEM_WIDTH-1:0]    w_m;
    logic                           w_push, w_pop;
    logic [PW-1:0]                  w_push_data, w_pop_data;
    t_q_status                      w_qs;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_DET_THRESHOLD) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_DET_THRESHOLD) ? 32'(r_thr) : '0;

    assign w_m = {i_r2t, i_r2c2, i_r2c1, i_r2c0, i_r1t, i_r1c2, i_r1c1, i_r1c0,
                  i_r0t, i_r0c2, i_r0c1, i_r0c0};

    aminv_front #(.E(ELEM_WIDTH), .F(FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_m       (w_m),
        .i_thr     (r_thr),
        .o_q_valid (w_push),
        .i_q_full  (w_qs.full),
        .o_q_data  (w_push_data)
    );

    aminv_fifo #(.W(PW), .DEPTH(2)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push && !w_qs.full),
        .i_data   (w_push_data),
        .i_pop    (w_pop),
        .o_data   (w_pop_data),
        .o_status (w_qs)
    );

    aminv_back #(.E(ELEM_WIDTH), .F(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!w_qs.empty),
        .i_q_data    (w_pop_data),
        .o_q_pop     (w_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_row_index (o_row_index),
        .o_c0        (o_out_c0),
        .o_c1        (o_out_c1),
        .o_c2        (o_out_c2),
        .o_t         (o_out_t),
        .o_singular  (o_singular),
        .o_last_row  (o_last_row)
    );

`ifndef SYNTHESIS
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_row == (o_row_index == LAST_ROW_IDX)))
        else $error("last_row does not match row index");
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_singular |-> (o_out_c0 == '0 && o_out_c1 == '0
                                       && o_out_c2 == '0 && o_out_t == '0))
        else $error("singular row carries nonzero data");
    a_rows_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_row |=>
            o_out_valid && o_row_index == $past(o_row_index) + 2'd1)
        else $error("rows of one matrix are not consecutive");
`endif

endmodule
